// File: hw/rtl/voxel_ray_traversal_assert.svh
// Assertion macros for the voxel ray walker checker.
// Relies on clk and arst_n being visible where the macros are used.
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH
// same-cycle implication, reset disables
`define VRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, reset disables
`define VRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hw/rtl/vrt_pkg.sv
// Shared types, codes and defaults for the voxel ray walker.
// No dependencies; used by the top level, divider, multiplier and checker.
package vrt_pkg;

	localparam int POS_W   = 32;
	localparam int HEAD_W  = 16;
	localparam int REACH_W = 32;

	localparam int CELL_BITS_DEF     = 20;
	localparam int POS_FRAC_BITS_DEF = 12;
	localparam int DIR_FRAC_BITS_DEF = 12;

	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_ANSWER = 1'b1;

	typedef enum logic [1:0] {
		KIND_QUERY  = 2'd0,
		KIND_HIT    = 2'd1,
		KIND_INSIDE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_START,
		PH_WAIT_STEP
	} phase_t;

	typedef enum logic [2:0] {
		ST_READY,
		ST_DIV,
		ST_DIVW,
		ST_DECIDE,
		ST_MUL,
		ST_MULW,
		ST_COMMIT,
		ST_EMIT
	} seq_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// File: hw/rtl/voxel_ray_traversal.sv
// Voxel ray walker top level: sequencer, ray state, output register.
// Depends on vrt_pkg, vrt_div and vrt_mul.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | action start_* heading_* reach occupied
//  out     | out_valid | out_stall | kind cell_* normal_*
//
// A start request gives its query from ST_EMIT once the output register can load; an
// answer that ends the ray (inside, hit, zero heading) likewise. An answer that steps
// runs the bit-serial divider once per nonzero axis, then the serial multiplier for
// the other axes. Zero heading components skip their divide and multiply.
// in_stall is high while a request is being worked; a finished result waits in
// the output register and the next request is taken meanwhile.
// arst_n clears the sequencer, ray phase and output valid; no clearing pass.
module voxel_ray_traversal #(
	parameter int CELL_BITS     = vrt_pkg::CELL_BITS_DEF,
	parameter int POS_FRAC_BITS = vrt_pkg::POS_FRAC_BITS_DEF,
	parameter int DIR_FRAC_BITS = vrt_pkg::DIR_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic signed [vrt_pkg::POS_W-1:0]   start_x,
	input  logic signed [vrt_pkg::POS_W-1:0]   start_y,
	input  logic signed [vrt_pkg::POS_W-1:0]   start_z,
	input  logic signed [vrt_pkg::HEAD_W-1:0]  heading_x,
	input  logic signed [vrt_pkg::HEAD_W-1:0]  heading_y,
	input  logic signed [vrt_pkg::HEAD_W-1:0]  heading_z,
	input  logic        [vrt_pkg::REACH_W-1:0] reach,
	input  logic                               occupied,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [1:0]                  kind,
	output logic signed [CELL_BITS-1:0]        cell_x,
	output logic signed [CELL_BITS-1:0]        cell_y,
	output logic signed [CELL_BITS-1:0]        cell_z,
	output logic signed [1:0]                  normal_x,
	output logic signed [1:0]                  normal_y,
	output logic signed [1:0]                  normal_z
);
	localparam int PW = vrt_pkg::POS_W;
	localparam int HW = vrt_pkg::HEAD_W;
	localparam int RW = vrt_pkg::REACH_W;

	// ray state
	vrt_pkg::phase_t               phase_q;
	vrt_pkg::seq_t                 seq_q, seq_d;
	logic [CELL_BITS-1:0]          cell_q [3];
	logic [PW-1:0]                 pos_q  [3];
	logic signed [HW-1:0]          head_q [3];
	logic [RW-1:0]                 reach_q;
	logic [1:0]                    last_axis_q;
	logic                          last_sign_q;

	// axis walk and running minimum
	logic [1:0]                    ax_q;
	logic [1:0]                    best_q;
	logic                          found_q;
	logic [RW-1:0]                 bt_q;
	vrt_pkg::kind_t                res_kind_q;

	// output register
	logic                          out_valid_q;
	vrt_pkg::kind_t                kind_q;
	logic [CELL_BITS-1:0]          ocell_q [3];
	logic signed [1:0]             onorm_q [3];

	logic                          accept;
	logic                          can_load;
	logic                          ax_last;
	logic                          head_zero;
	logic                          head_pos;
	logic                          all_zero;
	logic signed [HW-1:0]          head_cur;
	logic [PW-1:0]                 pos_cur;
	logic signed [CELL_BITS-1:0]   cell_cur;
	logic [PW-1:0]                 cext;
	logic [PW-1:0]                 face;
	logic [PW-1:0]                 ds;
	logic [PW-1:0]                 mag;
	logic [HW-1:0]                 ah;
	logic                          div_start;
	logic                          mul_start;
	logic [RW-1:0]                 div_q;
	logic [PW-1:0]                 adv;
	vrt_pkg::unit_sts_t            div_sts;
	vrt_pkg::unit_sts_t            mul_sts;
	logic                          fin_inside;
	logic                          fin_none;
	logic                          fin_hit;
	logic                          go_step;

	assign accept    = in_valid && (seq_q == vrt_pkg::ST_READY);
	assign in_stall  = (seq_q != vrt_pkg::ST_READY);
	assign can_load  = !out_valid_q || !out_stall;
	assign ax_last   = (ax_q == 2'd2);
	assign all_zero  = (head_q[0] == '0) && (head_q[1] == '0) && (head_q[2] == '0);

	// per-axis datapath, always indexed by the walk counter
	assign head_cur  = head_q[ax_q];
	assign pos_cur   = pos_q[ax_q];
	assign cell_cur  = signed'(cell_q[ax_q]);
	assign head_zero = (head_cur == '0);
	assign head_pos  = !head_cur[HW-1] && !head_zero;
	assign cext      = PW'(cell_cur);
	// upper face for a rising ray, lower face otherwise
	assign face      = (cext + PW'(head_pos)) << POS_FRAC_BITS;
	assign ds        = face - pos_cur;
	// distance pointing against the ray counts as zero
	always_comb begin
		if (head_pos)
			mag = (!ds[PW-1] && ds != '0) ? ds : '0;
		else
			mag = ds[PW-1] ? (~ds + PW'(1)) : '0;
	end
	assign ah = head_cur[HW-1] ? HW'(-head_cur) : HW'(head_cur);

	// decode of an accepted answer
	assign fin_inside = (phase_q == vrt_pkg::PH_WAIT_START) && occupied;
	assign fin_none   = (phase_q == vrt_pkg::PH_WAIT_START) && !occupied && all_zero;
	assign fin_hit    = (phase_q == vrt_pkg::PH_WAIT_STEP) && occupied;
	assign go_step    = ((phase_q == vrt_pkg::PH_WAIT_START) && !occupied && !all_zero)
		|| ((phase_q == vrt_pkg::PH_WAIT_STEP) && !occupied);

	vrt_div #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (ah),
		.quotient (div_q),
		.sts      (div_sts)
	);

	vrt_mul #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (bt_q),
		.multiplier   (ah),
		.product      (adv),
		.sts          (mul_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seq_q <= vrt_pkg::ST_READY;
		else
			seq_q <= seq_d;
	end

	// sequencer: next state and unit kicks
	always_comb begin
		seq_d     = seq_q;
		div_start = 1'b0;
		mul_start = 1'b0;
		case (seq_q)
			vrt_pkg::ST_READY: begin
				if (accept) begin
					if (action == vrt_pkg::ACT_START)
						seq_d = vrt_pkg::ST_EMIT;
					else if (fin_inside || fin_none || fin_hit)
						seq_d = vrt_pkg::ST_EMIT;
					else if (go_step)
						seq_d = vrt_pkg::ST_DIV;
				end
			end
			vrt_pkg::ST_DIV: begin
				if (head_zero)
					seq_d = ax_last ? vrt_pkg::ST_DECIDE : vrt_pkg::ST_DIV;
				else if (!div_sts.busy) begin
					div_start = 1'b1;
					seq_d     = vrt_pkg::ST_DIVW;
				end
			end
			vrt_pkg::ST_DIVW: begin
				if (div_sts.done)
					seq_d = ax_last ? vrt_pkg::ST_DECIDE : vrt_pkg::ST_DIV;
			end
			vrt_pkg::ST_DECIDE: begin
				if (!found_q || reach_q < bt_q)
					seq_d = vrt_pkg::ST_EMIT;
				else
					seq_d = vrt_pkg::ST_MUL;
			end
			vrt_pkg::ST_MUL: begin
				if (head_zero || ax_q == best_q)
					seq_d = ax_last ? vrt_pkg::ST_COMMIT : vrt_pkg::ST_MUL;
				else if (!mul_sts.busy) begin
					mul_start = 1'b1;
					seq_d     = vrt_pkg::ST_MULW;
				end
			end
			vrt_pkg::ST_MULW: begin
				if (mul_sts.done)
					seq_d = ax_last ? vrt_pkg::ST_COMMIT : vrt_pkg::ST_MUL;
			end
			vrt_pkg::ST_COMMIT: seq_d = vrt_pkg::ST_EMIT;
			vrt_pkg::ST_EMIT: begin
				if (can_load)
					seq_d = vrt_pkg::ST_READY;
			end
			default: seq_d = vrt_pkg::ST_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= vrt_pkg::PH_IDLE;
		else if (accept && action == vrt_pkg::ACT_START)
			phase_q <= vrt_pkg::PH_WAIT_START;
		else if (accept && (fin_inside || fin_none || fin_hit))
			phase_q <= vrt_pkg::PH_IDLE;
		else if (seq_q == vrt_pkg::ST_DECIDE && (!found_q || reach_q < bt_q))
			phase_q <= vrt_pkg::PH_IDLE;
		else if (seq_q == vrt_pkg::ST_COMMIT)
			phase_q <= vrt_pkg::PH_WAIT_STEP;
	end

	// ray state and axis walk
	always_ff @(posedge clk) begin
		case (seq_q)
			vrt_pkg::ST_READY: begin
				if (accept && action == vrt_pkg::ACT_START) begin
					pos_q[0]    <= start_x;
					pos_q[1]    <= start_y;
					pos_q[2]    <= start_z;
					cell_q[0]   <= CELL_BITS'(start_x >>> POS_FRAC_BITS);
					cell_q[1]   <= CELL_BITS'(start_y >>> POS_FRAC_BITS);
					cell_q[2]   <= CELL_BITS'(start_z >>> POS_FRAC_BITS);
					head_q[0]   <= heading_x;
					head_q[1]   <= heading_y;
					head_q[2]   <= heading_z;
					reach_q     <= reach;
					last_axis_q <= 2'd0;
					last_sign_q <= 1'b0;
					res_kind_q  <= vrt_pkg::KIND_QUERY;
				end else if (accept) begin
					ax_q    <= 2'd0;
					found_q <= 1'b0;
					if (fin_inside)
						res_kind_q <= vrt_pkg::KIND_INSIDE;
					else if (fin_none)
						res_kind_q <= vrt_pkg::KIND_NONE;
					else if (fin_hit)
						res_kind_q <= vrt_pkg::KIND_HIT;
				end
			end
			vrt_pkg::ST_DIV: begin
				if (head_zero)
					ax_q <= ax_q + 2'd1;
			end
			vrt_pkg::ST_DIVW: begin
				if (div_sts.done) begin
					// strict compare keeps ties on the lower axis
					if (!found_q || div_q < bt_q) begin
						best_q <= ax_q;
						bt_q   <= div_q;
					end
					found_q <= 1'b1;
					ax_q    <= ax_q + 2'd1;
				end
			end
			vrt_pkg::ST_DECIDE: begin
				ax_q <= 2'd0;
				if (!found_q || reach_q < bt_q)
					res_kind_q <= vrt_pkg::KIND_NONE;
			end
			vrt_pkg::ST_MUL: begin
				if (head_zero || ax_q == best_q)
					ax_q <= ax_last ? best_q : ax_q + 2'd1;
			end
			vrt_pkg::ST_MULW: begin
				if (mul_sts.done) begin
					pos_q[ax_q] <= head_cur[HW-1] ? pos_cur - adv : pos_cur + adv;
					ax_q        <= ax_last ? best_q : ax_q + 2'd1;
				end
			end
			vrt_pkg::ST_COMMIT: begin
				// ax_q holds the winning axis here
				pos_q[ax_q]  <= face;
				cell_q[ax_q] <= head_pos ? cell_q[ax_q] + CELL_BITS'(1)
					: cell_q[ax_q] - CELL_BITS'(1);
				last_sign_q  <= !head_pos;
				last_axis_q  <= ax_q;
				reach_q      <= reach_q - bt_q;
				res_kind_q   <= vrt_pkg::KIND_QUERY;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (seq_q == vrt_pkg::ST_EMIT && can_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (seq_q == vrt_pkg::ST_EMIT && can_load) begin
			kind_q <= res_kind_q;
			for (int i = 0; i < 3; i++) begin
				ocell_q[i] <= (res_kind_q == vrt_pkg::KIND_NONE) ? '0 : cell_q[i];
				// face normal points against the step
				if (res_kind_q == vrt_pkg::KIND_HIT && last_axis_q == 2'(i))
					onorm_q[i] <= last_sign_q ? 2'sb01 : 2'sb11;
				else
					onorm_q[i] <= 2'sb00;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign cell_x    = ocell_q[0];
	assign cell_y    = ocell_q[1];
	assign cell_z    = ocell_q[2];
	assign normal_x  = onorm_q[0];
	assign normal_y  = onorm_q[1];
	assign normal_z  = onorm_q[2];
endmodule

// File: hw/rtl/vrt_div.sv
// Bit-serial restoring divider: (dividend << DIR_FRAC_BITS) / divisor, saturated to 32 bits.
// Depends on vrt_pkg.
module vrt_div #(
	parameter int DIR_FRAC_BITS = vrt_pkg::DIR_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vrt_pkg::POS_W-1:0]    dividend,
	input  logic [vrt_pkg::HEAD_W-1:0]   divisor,
	output logic [vrt_pkg::REACH_W-1:0]  quotient,
	output vrt_pkg::unit_sts_t           sts
);
	localparam int DW = vrt_pkg::POS_W + DIR_FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]                  dvd_q;
	logic [vrt_pkg::HEAD_W-1:0]     dvs_q;
	logic [vrt_pkg::HEAD_W-1:0]     rem_q;
	logic [vrt_pkg::REACH_W-1:0]    quo_q;
	logic                           ovf_q;
	logic [CW-1:0]                  cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [vrt_pkg::HEAD_W:0]       trial;
	logic [vrt_pkg::HEAD_W:0]       diff;
	logic                           ge;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {dividend, {DIR_FRAC_BITS{1'b0}}};
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= CW'(DW);
		end else if (busy_q) begin
			rem_q <= ge ? diff[vrt_pkg::HEAD_W-1:0] : trial[vrt_pkg::HEAD_W-1:0];
			quo_q <= {quo_q[vrt_pkg::REACH_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[vrt_pkg::REACH_W-1];
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign quotient = ovf_q ? '1 : quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// File: hw/rtl/vrt_mul.sv
// Shift-add serial multiplier, one multiplier bit per cycle, result >> DIR_FRAC_BITS.
// Depends on vrt_pkg.
module vrt_mul #(
	parameter int DIR_FRAC_BITS = vrt_pkg::DIR_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vrt_pkg::REACH_W-1:0]  multiplicand,
	input  logic [vrt_pkg::HEAD_W-1:0]   multiplier,
	output logic [vrt_pkg::POS_W-1:0]    product,
	output vrt_pkg::unit_sts_t           sts
);
	localparam int MW = vrt_pkg::REACH_W;
	localparam int BW = vrt_pkg::HEAD_W;
	localparam int CW = $clog2(BW + 1);

	logic [MW-1:0]    mcand_q;
	logic [MW-1:0]    hi_q;
	logic [BW-1:0]    lo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MW:0]      sum;
	logic [MW+BW-1:0] full;
	logic [MW+BW-1:0] shifted;

	assign sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign full    = {hi_q, lo_q};
	assign shifted = full >> DIR_FRAC_BITS;
	assign product = shifted[vrt_pkg::POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= multiplicand;
			hi_q    <= '0;
			lo_q    <= multiplier;
			cnt_q   <= CW'(BW);
		end else if (busy_q) begin
			hi_q  <= sum[MW:1];
			lo_q  <= {sum[0], lo_q[BW-1:1]};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// File: hw/rtl/vrt_checker.sv
// Port-level checks on the voxel ray walker, bound to the top level.
// Depends on vrt_pkg and voxel_ray_traversal_assert.svh.
`include "voxel_ray_traversal_assert.svh"
module vrt_checker #(
	parameter int CELL_BITS = vrt_pkg::CELL_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic        [1:0]                  kind,
	input logic signed [CELL_BITS-1:0]        cell_x,
	input logic signed [CELL_BITS-1:0]        cell_y,
	input logic signed [CELL_BITS-1:0]        cell_z,
	input logic signed [1:0]                  normal_x,
	input logic signed [1:0]                  normal_y,
	input logic signed [1:0]                  normal_z
);
	`VRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(cell_x), "stalled result changed")
	`VRT_ASSERT_NOW(a_none_zero, out_valid && kind == vrt_pkg::KIND_NONE, cell_x == '0 && cell_y == '0 && cell_z == '0, "none result carries a cell")
	`VRT_ASSERT_NOW(a_hit_normal, out_valid && kind == vrt_pkg::KIND_HIT, $countones({normal_x != 2'sb00, normal_y != 2'sb00, normal_z != 2'sb00}) == 1, "hit normal not on one axis")
	`VRT_ASSERT_NOW(a_norm_only_hit, out_valid && kind != vrt_pkg::KIND_HIT, normal_x == 2'sb00 && normal_y == 2'sb00 && normal_z == 2'sb00, "normal outside a hit")
	`VRT_ASSERT_NEXT(a_out_hold_rest, out_valid && out_stall, $stable(cell_y) && $stable(cell_z) && $stable(normal_x) && $stable(normal_y) && $stable(normal_z), "stalled result changed")
endmodule

bind voxel_ray_traversal vrt_checker #(.CELL_BITS(CELL_BITS)) u_vrt_checker (.*);
